/* design/chc_pkg.sv */
// ----------------------------------------------------------------------------
// chc_pkg
// Shared constants, ramp color table and register map of the count heatmap
// colorizer.
// ----------------------------------------------------------------------------
package chc_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int RAMP_COLORS   = 6;
   localparam int RAMP_SEGMENTS = RAMP_COLORS - 1;

   // quotient of count*5*2^F / maximum when count < maximum fits in F+3 bits
   localparam int QUOT_W = FRACTION_BITS + 3;
   localparam int ITER_W = $clog2(QUOT_W);
   localparam int FRAC_W = FRACTION_BITS + 1;
   localparam int PROD_W = FRACTION_BITS + 11;

   localparam logic [QUOT_W-1:0] POS_TOP  = QUOT_W'(RAMP_SEGMENTS) << FRACTION_BITS;
   localparam logic [2:0]        SEG_LAST = 3'(RAMP_SEGMENTS - 1);

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_FIXED_MAXIMUM = '0;

   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_MAP  = 1'b1;

   // control colors as round(255*c), {red, green, blue}
   localparam logic [7:0] RAMP_BYTES [0:RAMP_COLORS-1][0:2] = '{
      '{8'd38,  8'd26,  8'd102},
      '{8'd26,  8'd153, 8'd217},
      '{8'd38,  8'd204, 8'd89},
      '{8'd242, 8'd230, 8'd38},
      '{8'd230, 8'd51,  8'd26},
      '{8'd255, 8'd255, 8'd255}
   };

endpackage

/* design/count_heatmap_colorizer.sv */
// ----------------------------------------------------------------------------
// count_heatmap_colorizer
// Maps per-pixel counts onto a six-color heatmap ramp, giving RGB bytes.
// ----------------------------------------------------------------------------
// Each frame is sent twice: scan requests (tuser = 0) update the running
// maximum without leaving the idle state and give no response; map requests
// (tuser = 1) give one RGB response. A map request passes from acceptance
// through a restoring divider (one quotient bit per cycle), a shared blend
// multiplier (one channel per cycle) and the response register, where it may
// wait for the previous color to leave before the next request is accepted.
// Counts at or above the maximum, and a zero maximum, skip the divider. The
// response register lets a new request be taken while a color waits. A map
// request with tlast set clears the scanned maximum.
module count_heatmap_colorizer (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // count
   input  logic                            req_tuser,   // mode
   input  logic                            req_tlast,   // last_pixel
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // blue, green, red
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [chc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import chc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_BLEND = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        fixed_max_ff, fixed_max_in;
   logic [31:0]        scan_max_ff, scan_max_in;
   logic [31:0]        divisor_ff, divisor_in;
   logic [31:0]        rem_ff, rem_in;
   logic [QUOT_W-1:0]  num_ff, num_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [1:0]         chan_ff, chan_in;
   logic [23:0]        rgb_ff, rgb_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;

   logic               req_take, csr_write;
   logic [31:0]        maximum;
   logic [34:0]        count5;
   logic [32:0]        trial;
   logic [33:0]        diff;
   logic               ge;
   logic [2:0]         seg_raw, seg;
   logic [FRAC_W-1:0]  frac;
   logic [7:0]         c_lo, c_hi;
   logic signed [8:0]  delta;
   logic signed [PROD_W-1:0] prod, base, sum;
   logic [QUOT_W-1:0]  seg_offset;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == ADDR_FIXED_MAXIMUM) ? fixed_max_ff : 32'd0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign maximum = (fixed_max_ff != 32'd0) ? fixed_max_ff : scan_max_ff;
   assign count5  = {3'b000, req_tdata} + {1'b0, req_tdata, 2'b00};

   // divider step
   assign trial = {rem_ff, num_ff[QUOT_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor_ff};
   assign ge    = !diff[33];

   // blend step
   assign seg_raw    = quot_ff[QUOT_W-1:FRACTION_BITS];
   assign seg        = (seg_raw > SEG_LAST) ? SEG_LAST : seg_raw;
   assign seg_offset = QUOT_W'(seg) << FRACTION_BITS;
   assign frac       = FRAC_W'(quot_ff - seg_offset);
   assign c_lo       = RAMP_BYTES[seg][chan_ff];
   assign c_hi       = RAMP_BYTES[seg + 3'd1][chan_ff];
   assign delta      = $signed({1'b0, c_hi}) - $signed({1'b0, c_lo});
   assign prod       = delta * $signed({1'b0, frac});
   assign base       = $signed({3'b000, c_lo, {FRACTION_BITS{1'b0}}});
   assign sum        = base + prod + $signed(PROD_W'(1) << (FRACTION_BITS - 1));

   always_comb begin
      state_in     = state_ff;
      fixed_max_in = fixed_max_ff;
      scan_max_in  = scan_max_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quot_in      = quot_ff;
      iter_in      = iter_ff;
      chan_in      = chan_ff;
      rgb_in       = rgb_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write && csr_paddr == ADDR_FIXED_MAXIMUM) begin
         fixed_max_in = csr_pwdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser == MODE_SCAN) begin
                  if (req_tdata > scan_max_ff) begin
                     scan_max_in = req_tdata;
                  end
               end else begin
                  if (req_tlast) begin
                     scan_max_in = 32'd0;
                  end
                  divisor_in = maximum;
                  rem_in     = count5[34:3];
                  num_in     = {count5[2:0], {FRACTION_BITS{1'b0}}};
                  iter_in    = ITER_W'(QUOT_W - 1);
                  chan_in    = 2'd0;
                  if (maximum == 32'd0) begin
                     quot_in  = '0;
                     state_in = ST_BLEND;
                  end else if (req_tdata >= maximum) begin
                     quot_in  = POS_TOP;
                     state_in = ST_BLEND;
                  end else begin
                     quot_in  = '0;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[31:0] : trial[31:0];
            num_in  = num_ff << 1;
            quot_in = {quot_ff[QUOT_W-2:0], ge};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            rgb_in  = {sum[FRACTION_BITS+7:FRACTION_BITS], rgb_ff[23:8]};
            chan_in = chan_ff + 2'd1;
            if (chan_ff == 2'd2) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rgb_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fixed_max_ff <= 32'd0;
         scan_max_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fixed_max_ff <= fixed_max_in;
         scan_max_ff  <= scan_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quot_ff     <= quot_in;
      iter_ff     <= iter_in;
      chan_ff     <= chan_in;
      rgb_ff      <= rgb_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* design/chc_checker.sv */
// ----------------------------------------------------------------------------
// chc_checker
// Port-level checks of the count heatmap colorizer, bound to the top level.
// ----------------------------------------------------------------------------
module chc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import chc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_map_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_MAP |=> !req_tready)
      else $error("ready after map request");

   a_scan_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_SCAN |=> req_tready)
      else $error("scan request stalled the input");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind count_heatmap_colorizer chc_checker u_chc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
